// ===== hw/rtl/gvc_pkg.sv =====
// gvc_pkg: types, constants and helpers for the gravity verlet collision step
// used by gravity_verlet_collision_step; no dependencies

package gvc_pkg;

  localparam int MAX_PLANETS = 16;
  localparam int PIDX_W = (MAX_PLANETS > 1) ? $clog2(MAX_PLANETS) : 1;
  localparam int CNT_W = $clog2(MAX_PLANETS + 1);
  localparam int ACC_W = 34 + CNT_W;

  // operation codes
  localparam logic [1:0] OP_PLACE = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PLANET_COUNT    = 3'd0;
  localparam logic [2:0] REG_OBJECT_RADIUS   = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH    = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_TIME_STEP       = 3'd4;
  localparam logic [2:0] REG_WORMHOLE_X      = 3'd5;
  localparam logic [2:0] REG_WORMHOLE_Y      = 3'd6;
  localparam logic [2:0] REG_WORMHOLE_RADIUS = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         planet_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [31:0]        gravity_value;
    logic [15:0]        planet_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               hit_planet;
    logic               out_of_bounds;
    logic               in_wormhole;
    logic               frozen;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        g;
    logic [15:0]        r;
  } planet_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/gravity_verlet_collision_step.sv =====
// gravity_verlet_collision_step: one body under planet gravity, velocity verlet
// depends on gvc_pkg
//
// Usage: items enter on in_valid/in_stall, one result item leaves on
// out_valid/out_stall for every item. Registers are written on cfg_write with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. Place, load and unused items
// go straight to the result. A tick walks the planet table in a single-port
// memory, one planet at a time: per planet a 32-step square root and four
// 64-step restoring divisions run on one shared divider. The first tick after
// a place or reset runs the gravity sum twice. A frozen tick goes straight to
// the result.
// The result waits in an output register; a new item is taken while it waits,
// and the next result is held back until the receiver takes the old one.
// Reset (rst, synchronous) clears body state and loads register defaults; the
// planet table is not cleared and must be loaded before it is used.
// While out_stall is high the result holds and the block stalls at the end of
// its next item.

module gravity_verlet_collision_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gvc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gvc_pkg::out_item_t  out_data,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [4:0] {
    IDLE, G_IDX, G_LOAD, G_SQX, G_SQY, G_SUM, G_SQRT, G_DIST, G_DIV, G_DIVD,
    G_MX, G_MY, G_ACC, G_END, P1, P2, P3, P4, P5, V1, V2, C_IDX, C_LOAD,
    E_CHK, OV_M1, OV_M2, OV_M3, OV_CMP, FIN
  } state_t;

  typedef enum logic [1:0] {D_Q1, D_M, D_UX, D_UY} div_sel_t;

  // configuration
  logic [4:0]         cfg_count;
  logic [15:0]        object_radius;
  logic [11:0]        screen_width;
  logic [11:0]        screen_height;
  logic [15:0]        time_step;
  logic signed [31:0] wormhole_x;
  logic signed [31:0] wormhole_y;
  logic [15:0]        wormhole_radius;

  // body state
  logic signed [31:0] body_x, body_y, speed_x, speed_y, accel_x, accel_y;
  logic               need_init, stopped;

  // sequencer
  state_t                     state;
  logic                       ret_new;
  logic                       axis;
  logic [gvc_pkg::CNT_W-1:0]  idx;
  logic                       sx_neg, sy_neg, k;
  logic [31:0]                adx, ady;
  logic [63:0]                d2;
  logic [63:0]                sq_v, sq_res, sq_bit;
  logic [4:0]                 sq_cnt;
  logic [32:0]                dlen;
  logic [63:0]                div_n, div_q;
  logic [32:0]                div_r;
  logic [5:0]                 div_cnt;
  div_sel_t                   div_sel;
  logic [32:0]                m;
  logic [30:0]                ux, uy;
  logic signed [gvc_pkg::ACC_W-1:0] accx, accy;
  logic signed [31:0]         gax, gay;
  logic signed [32:0]         tx;
  logic signed [31:0]         tt;
  logic                       far, ov_wh;
  logic [15:0]                orad;
  logic [64:0]                ov_s;
  logic                       hp, oob, wh;
  logic [65:0]                mul_p;
  logic signed [50:0]         sm_p;

  // planet table
  gvc_pkg::planet_t           mem [gvc_pkg::MAX_PLANETS];
  gvc_pkg::planet_t           mem_q;

  logic in_acc;
  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;

  // active planet count
  logic [gvc_pkg::CNT_W-1:0] cnt_n;
  assign cnt_n = (32'(cfg_count) > gvc_pkg::MAX_PLANETS) ?
                 gvc_pkg::CNT_W'(gvc_pkg::MAX_PLANETS) : gvc_pkg::CNT_W'(cfg_count);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == gvc_pkg::OP_LOAD &&
        32'(in_data.planet_index) < gvc_pkg::MAX_PLANETS) begin
      mem[gvc_pkg::PIDX_W'(in_data.planet_index)] <= '{
        x: in_data.coord_x, y: in_data.coord_y,
        g: in_data.gravity_value, r: in_data.planet_radius};
    end
    if (state == G_IDX || state == C_IDX) begin
      mem_q <= mem[idx[gvc_pkg::PIDX_W-1:0]];
    end
  end

  // distance from body to a planet or the wormhole
  logic signed [31:0] tgt_x, tgt_y;
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        adx_w, ady_w;
  assign tgt_x = (state == E_CHK) ? wormhole_x : mem_q.x;
  assign tgt_y = (state == E_CHK) ? wormhole_y : mem_q.y;
  assign dx_c  = {tgt_x[31], tgt_x} - {body_x[31], body_x};
  assign dy_c  = {tgt_y[31], tgt_y} - {body_y[31], body_y};
  assign adx_w = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ady_w = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);

  // shared unsigned multiplier operands
  logic [32:0] mul_a, mul_b;
  logic [31:0] adx_h, ady_h;
  logic [24:0] rs;
  assign adx_h = adx >> k;
  assign ady_h = ady >> k;
  assign rs    = {17'(object_radius) + 17'(orad), 8'd0};
  always_comb begin
    case (state)
      G_SQX:   begin mul_a = 33'(adx_h); mul_b = 33'(adx_h); end
      G_SQY:   begin mul_a = 33'(ady_h); mul_b = 33'(ady_h); end
      G_MX:    begin mul_a = m;          mul_b = 33'(ux);    end
      G_MY:    begin mul_a = m;          mul_b = 33'(uy);    end
      OV_M1:   begin mul_a = 33'(adx);   mul_b = 33'(adx);   end
      OV_M2:   begin mul_a = 33'(ady);   mul_b = 33'(ady);   end
      OV_M3:   begin mul_a = 33'(rs);    mul_b = 33'(rs);    end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  // shared signed multiplier by the time step
  logic signed [33:0] sm_a;
  logic signed [16:0] sm_h;
  logic signed [31:0] sel_speed, sel_accel, sel_g, sel_body;
  assign sm_h      = $signed({1'b0, time_step});
  assign sel_speed = axis ? speed_y : speed_x;
  assign sel_accel = axis ? accel_y : accel_x;
  assign sel_g     = axis ? gay : gax;
  assign sel_body  = axis ? body_y : body_x;
  always_comb begin
    case (state)
      P1:      sm_a = 34'(sel_speed);
      P2:      sm_a = 34'(sel_accel);
      P4:      sm_a = 34'(tt);
      V1:      sm_a = 34'(sel_g) + 34'(sel_accel);
      default: sm_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    sm_p  <= sm_a * sm_h;
  end

  // square root step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = sq_v >= sq_t;

  // division step
  logic [33:0] div_rr, div_sub;
  logic        div_ge;
  assign div_rr  = {div_r, div_n[63]};
  assign div_ge  = div_rr >= {1'b0, dlen};
  assign div_sub = div_rr - {1'b0, dlen};

  // position and velocity sums
  logic signed [63:0] pos_sum, vel_sum;
  assign pos_sum = 64'(sel_body) + 64'(tx) + 64'(sm_p >>> 17);
  assign vel_sum = 64'(sel_speed) + 64'(sm_p >>> 17);

  // gravity term of one planet
  logic [32:0] term;
  assign term = mul_p[62:30];

  // edge test
  logic signed [33:0] er, bxs, bys;
  logic               edge_c;
  assign er  = 34'({object_radius, 8'd0});
  assign bxs = 34'(body_x);
  assign bys = 34'(body_y);
  assign edge_c = (bxs - er < 0) || (bxs + er > $signed(34'({screen_width, 16'd0}))) ||
                  (bys - er < 0) || (bys + er > $signed(34'({screen_height, 16'd0})));

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      cfg_count <= 5'd0;
      object_radius <= 16'd2560;
      screen_width <= 12'd800;
      screen_height <= 12'd600;
      time_step <= 16'd1092;
      wormhole_x <= '0;
      wormhole_y <= '0;
      wormhole_radius <= '0;
      body_x <= '0; body_y <= '0;
      speed_x <= '0; speed_y <= '0;
      accel_x <= '0; accel_y <= '0;
      need_init <= 1'b1;
      stopped <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          gvc_pkg::REG_PLANET_COUNT:    cfg_count <= cfg_data[4:0];
          gvc_pkg::REG_OBJECT_RADIUS:   object_radius <= cfg_data[15:0];
          gvc_pkg::REG_SCREEN_WIDTH:    screen_width <= cfg_data[11:0];
          gvc_pkg::REG_SCREEN_HEIGHT:   screen_height <= cfg_data[11:0];
          gvc_pkg::REG_TIME_STEP:       time_step <= cfg_data[15:0];
          gvc_pkg::REG_WORMHOLE_X:      wormhole_x <= cfg_data;
          gvc_pkg::REG_WORMHOLE_Y:      wormhole_y <= cfg_data;
          gvc_pkg::REG_WORMHOLE_RADIUS: wormhole_radius <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            hp <= 1'b0; oob <= 1'b0; wh <= 1'b0;
            idx <= '0;
            accx <= '0; accy <= '0;
            axis <= 1'b0;
            unique case (in_data.operation)
              gvc_pkg::OP_PLACE: begin
                body_x <= in_data.coord_x; body_y <= in_data.coord_y;
                speed_x <= '0; speed_y <= '0;
                accel_x <= '0; accel_y <= '0;
                need_init <= 1'b1;
                stopped <= 1'b0;
                state <= FIN;
              end
              gvc_pkg::OP_TICK: begin
                if (!stopped) begin
                  ret_new <= !need_init;
                  state <= need_init ? G_IDX : P1;
                end else begin
                  state <= FIN;
                end
              end
              default: state <= FIN;
            endcase
          end
        end
        // gravity sum over the table
        G_IDX: state <= (idx == cnt_n) ? G_END : G_LOAD;
        G_LOAD: begin
          if (dx_c == 0 && dy_c == 0) begin
            idx <= idx + 1'b1;
            state <= G_IDX;
          end else begin
            adx <= adx_w[31:0]; ady <= ady_w[31:0];
            sx_neg <= dx_c[32]; sy_neg <= dy_c[32];
            k <= adx_w[31] | ady_w[31];
            state <= G_SQX;
          end
        end
        G_SQX: state <= G_SQY;
        G_SQY: begin
          d2 <= mul_p[63:0];
          state <= G_SUM;
        end
        G_SUM: begin
          sq_v <= d2 + mul_p[63:0];
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          sq_cnt <= '0;
          state <= G_SQRT;
        end
        G_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) state <= G_DIST;
        end
        G_DIST: begin
          dlen <= k ? {sq_res[31:0], 1'b0} : {1'b0, sq_res[31:0]};
          if (sq_res[31:0] == '0) begin
            idx <= idx + 1'b1;
            state <= G_IDX;
          end else begin
            div_n <= 64'({mem_q.g, 20'd0});
            div_r <= '0; div_cnt <= '0; div_sel <= D_Q1;
            state <= G_DIV;
          end
        end
        G_DIV: begin
          div_r <= div_ge ? div_sub[32:0] : div_rr[32:0];
          div_q <= {div_q[62:0], div_ge};
          div_n <= div_n << 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd63) state <= G_DIVD;
        end
        G_DIVD: begin
          div_r <= '0; div_cnt <= '0;
          case (div_sel)
            D_Q1: begin
              div_n <= (div_q > 64'h7ff_ffff_ffff) ? 64'({43'h7ff_ffff_ffff, 20'd0}) :
                                                     64'({div_q[42:0], 20'd0});
              div_sel <= D_M;
              state <= G_DIV;
            end
            D_M: begin
              m <= (div_q > 64'h1_0000_0000) ? 33'h1_0000_0000 : div_q[32:0];
              div_n <= 64'({adx, 30'd0});
              div_sel <= D_UX;
              state <= G_DIV;
            end
            D_UX: begin
              ux <= (div_q > 64'h4000_0000) ? 31'h4000_0000 : div_q[30:0];
              div_n <= 64'({ady, 30'd0});
              div_sel <= D_UY;
              state <= G_DIV;
            end
            default: begin
              uy <= (div_q > 64'h4000_0000) ? 31'h4000_0000 : div_q[30:0];
              state <= G_MX;
            end
          endcase
        end
        G_MX: state <= G_MY;
        G_MY: begin
          accx <= sx_neg ? accx - gvc_pkg::ACC_W'(term) : accx + gvc_pkg::ACC_W'(term);
          state <= G_ACC;
        end
        G_ACC: begin
          accy <= sy_neg ? accy - gvc_pkg::ACC_W'(term) : accy + gvc_pkg::ACC_W'(term);
          idx <= idx + 1'b1;
          state <= G_IDX;
        end
        G_END: begin
          gax <= gvc_pkg::sat32(64'(accx));
          gay <= gvc_pkg::sat32(64'(accy));
          axis <= 1'b0;
          if (ret_new) begin
            state <= V1;
          end else begin
            accel_x <= gvc_pkg::sat32(64'(accx));
            accel_y <= gvc_pkg::sat32(64'(accy));
            need_init <= 1'b0;
            state <= P1;
          end
        end
        // position update, one axis at a time
        P1: state <= P2;
        P2: begin
          tx <= 33'(sm_p >>> 16);
          state <= P3;
        end
        P3: begin
          tt <= 32'(sm_p >>> 16);
          state <= P4;
        end
        P4: state <= P5;
        P5: begin
          if (axis) body_y <= gvc_pkg::sat32(pos_sum);
          else body_x <= gvc_pkg::sat32(pos_sum);
          axis <= !axis;
          if (axis) begin
            idx <= '0; accx <= '0; accy <= '0;
            ret_new <= 1'b1;
            state <= G_IDX;
          end else begin
            state <= P1;
          end
        end
        // velocity update
        V1: state <= V2;
        V2: begin
          if (axis) speed_y <= gvc_pkg::sat32(vel_sum);
          else speed_x <= gvc_pkg::sat32(vel_sum);
          axis <= !axis;
          if (axis) begin
            accel_x <= gax; accel_y <= gay;
            idx <= '0;
            state <= C_IDX;
          end else begin
            state <= V1;
          end
        end
        // collision checks: planets, edges, wormhole
        C_IDX: state <= (idx == cnt_n) ? E_CHK : C_LOAD;
        C_LOAD: begin
          adx <= adx_w[31:0]; ady <= ady_w[31:0];
          far <= (adx_w[32:25] != '0) || (ady_w[32:25] != '0);
          orad <= mem_q.r;
          k <= 1'b0;
          ov_wh <= 1'b0;
          state <= OV_M1;
        end
        E_CHK: begin
          if (edge_c) begin
            oob <= 1'b1;
            stopped <= 1'b1;
            state <= FIN;
          end else begin
            adx <= adx_w[31:0]; ady <= ady_w[31:0];
            far <= (adx_w[32:25] != '0) || (ady_w[32:25] != '0);
            orad <= wormhole_radius;
            k <= 1'b0;
            ov_wh <= 1'b1;
            state <= OV_M1;
          end
        end
        OV_M1: state <= OV_M2;
        OV_M2: begin
          ov_s <= 65'(mul_p);
          state <= OV_M3;
        end
        OV_M3: begin
          ov_s <= ov_s + 65'(mul_p);
          state <= OV_CMP;
        end
        OV_CMP: begin
          if (ov_wh) begin
            wh <= !far && (66'(ov_s) < mul_p);
            if (!far && (66'(ov_s) < mul_p)) stopped <= 1'b1;
            state <= FIN;
          end else if (!far && (66'(ov_s) < mul_p)) begin
            hp <= 1'b1;
            stopped <= 1'b1;
            state <= FIN;
          end else begin
            idx <= idx + 1'b1;
            state <= C_IDX;
          end
        end
        FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data <= '{
              pos_x: body_x, pos_y: body_y, vel_x: speed_x, vel_y: speed_y,
              hit_planet: hp, out_of_bounds: oob, in_wormhole: wh, frozen: stopped};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for gravity_verlet_collision_step
// depends on gvc_pkg and the block itself; holds its own fixed-point body predictor

module tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  gvc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gvc_pkg::out_item_t out_data;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  gravity_verlet_collision_step u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predicted register copy
  longint cnt_reg = 0, obj_r = 2560, scr_w = 800, scr_h = 600, step_h = 1092;
  longint hole_x = 0, hole_y = 0, hole_r = 0;
  // predicted planet table and body
  longint planet_x [16], planet_y [16], planet_r [16];
  longint unsigned planet_g [16];
  longint body_px = 0, body_py = 0, body_vx = 0, body_vy = 0, body_ax = 0, body_ay = 0;
  bit     need_init = 1'b1, stopped = 1'b0;

  gvc_pkg::out_item_t body_states [$];
  logic [31:0] next_cfg [8];
  int  mismatches = 0, items_sent = 0, results_seen = 0, ticks_sent = 0, hits_seen = 0;
  bit  quiet = 1'b0, hold_req = 1'b0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // summed pull of the active planets at one point, saturated
  function automatic void gravity_sum(input longint bx, input longint by,
                                      output longint gx, output longint gy);
    longint sx, sy, dx, dy, n;
    longint unsigned adx, ady, d2, dlen, q1, m, ux, uy;
    int k;
    sx = 0;
    sy = 0;
    n = (cnt_reg < 16) ? cnt_reg : 16;
    for (int i = 0; i < n; i++) begin
      dx = planet_x[i] - bx;
      dy = planet_y[i] - by;
      if (dx == 0 && dy == 0) continue;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      k = (adx >= 64'h8000_0000 || ady >= 64'h8000_0000) ? 1 : 0;
      d2 = (adx >> k) * (adx >> k) + (ady >> k) * (ady >> k);
      dlen = int_sqrt(d2) << k;
      if (dlen == 0) continue;
      q1 = (planet_g[i] << 20) / dlen;
      if (q1 > (64'd1 << 43) - 1) q1 = (64'd1 << 43) - 1;
      m = (q1 << 20) / dlen;
      if (m > (64'd1 << 32)) m = 64'd1 << 32;
      ux = (adx << 30) / dlen;
      uy = (ady << 30) / dlen;
      if (ux > (64'd1 << 30)) ux = 64'd1 << 30;
      if (uy > (64'd1 << 30)) uy = 64'd1 << 30;
      if (dx < 0) sx = sx - longint'((m * ux) >> 30);
      else sx = sx + longint'((m * ux) >> 30);
      if (dy < 0) sy = sy - longint'((m * uy) >> 30);
      else sy = sy + longint'((m * uy) >> 30);
    end
    gx = clamp32(sx);
    gy = clamp32(sy);
  endfunction

  // strict circle overlap, radii q8.8 and centres q16.16
  function automatic bit circles_touch(input longint x0, input longint y0, input longint x1,
                                       input longint y1, input longint ra, input longint rb);
    longint dx, dy;
    longint unsigned adx, ady, rs;
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rs = (ra + rb) << 8;
    if (adx >= (64'd1 << 25) || ady >= (64'd1 << 25)) return 1'b0;
    return rs * rs > adx * adx + ady * ady;
  endfunction

  // body state after one item
  function automatic gvc_pkg::out_item_t advance_body(input gvc_pkg::in_item_t it);
    gvc_pkg::out_item_t o;
    bit hp, oob, whl;
    longint t, nax, nay, n, r;
    hp = 1'b0;
    oob = 1'b0;
    whl = 1'b0;
    n = (cnt_reg < 16) ? cnt_reg : 16;
    case (it.operation)
      gvc_pkg::OP_PLACE: begin
        body_px = it.coord_x;
        body_py = it.coord_y;
        body_vx = 0; body_vy = 0; body_ax = 0; body_ay = 0;
        need_init = 1'b1;
        stopped = 1'b0;
      end
      gvc_pkg::OP_LOAD: begin
        planet_x[it.planet_index] = it.coord_x;
        planet_y[it.planet_index] = it.coord_y;
        planet_g[it.planet_index] = it.gravity_value;
        planet_r[it.planet_index] = it.planet_radius;
      end
      gvc_pkg::OP_TICK: begin
        if (!stopped) begin
          if (need_init) begin
            gravity_sum(body_px, body_py, body_ax, body_ay);
            need_init = 1'b0;
          end
          t = (body_ax * step_h) >>> 16;
          body_px = clamp32(body_px + ((body_vx * step_h) >>> 16) + ((t * step_h) >>> 17));
          t = (body_ay * step_h) >>> 16;
          body_py = clamp32(body_py + ((body_vy * step_h) >>> 16) + ((t * step_h) >>> 17));
          gravity_sum(body_px, body_py, nax, nay);
          body_vx = clamp32(body_vx + (((nax + body_ax) * step_h) >>> 17));
          body_vy = clamp32(body_vy + (((nay + body_ay) * step_h) >>> 17));
          body_ax = nax;
          body_ay = nay;
          for (int i = 0; i < n && !hp; i++)
            hp = circles_touch(body_px, body_py, planet_x[i], planet_y[i], obj_r, planet_r[i]);
          r = obj_r << 8;
          if (!hp)
            oob = (body_px - r < 0) || (body_px + r > (scr_w << 16)) ||
                  (body_py - r < 0) || (body_py + r > (scr_h << 16));
          if (!hp && !oob)
            whl = circles_touch(body_px, body_py, hole_x, hole_y, obj_r, hole_r);
          if (hp || oob || whl) stopped = 1'b1;
        end
      end
      default: ;
    endcase
    o.pos_x = body_px[31:0];
    o.pos_y = body_py[31:0];
    o.vel_x = body_vx[31:0];
    o.vel_y = body_vy[31:0];
    o.hit_planet = hp;
    o.out_of_bounds = oob;
    o.in_wormhole = whl;
    o.frozen = stopped;
    return o;
  endfunction

  function automatic gvc_pkg::in_item_t mk_in(input logic [1:0] op, input logic [3:0] idx,
                                              input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] g, input logic [15:0] r);
    gvc_pkg::in_item_t it;
    it.operation = op;
    it.planet_index = idx;
    it.coord_x = x;
    it.coord_y = y;
    it.gravity_value = g;
    it.planet_radius = r;
    return it;
  endfunction

  function automatic gvc_pkg::out_item_t mk_out(input logic [31:0] x, input logic [31:0] y,
                                                input logic [3:0] flags);
    gvc_pkg::out_item_t o;
    o.pos_x = x;
    o.pos_y = y;
    o.vel_x = '0;
    o.vel_y = '0;
    {o.hit_planet, o.out_of_bounds, o.in_wormhole, o.frozen} = flags;
    return o;
  endfunction

  // random item, mostly motion on screen with some noise
  function automatic gvc_pkg::in_item_t random_item();
    gvc_pkg::in_item_t it;
    int pick;
    it = mk_in(gvc_pkg::OP_TICK, 4'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.operation = gvc_pkg::OP_PLACE;
      if (pick >= 2) begin
        it.coord_x = $urandom_range(0, int'(scr_w)) * 65536 + $urandom_range(0, 65535);
        it.coord_y = $urandom_range(0, int'(scr_h)) * 65536 + $urandom_range(0, 65535);
      end
    end else if (pick < 24) begin
      it.operation = gvc_pkg::OP_LOAD;
      if (pick >= 15) begin
        it.coord_x = $urandom_range(0, int'(scr_w)) * 65536;
        it.coord_y = $urandom_range(0, int'(scr_h)) * 65536;
        it.gravity_value = $urandom_range(0, 32'h1000_0000);
        it.planet_radius = $urandom_range(0, 8192);
      end
    end else if (pick < 28) begin
      it.operation = 2'd3;
    end
    return it;
  endfunction

  task automatic send(input gvc_pkg::in_item_t it, input bit typed,
                      input gvc_pkg::out_item_t want);
    int gap;
    gvc_pkg::out_item_t pred;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pred = advance_body(it);
    body_states.push_back(typed ? want : pred);
    items_sent++;
    if (it.operation == gvc_pkg::OP_TICK) ticks_sent++;
  endtask

  // write all registers once the block has drained
  task automatic apply_cfg();
    in_valid <= 1'b0;
    while (body_states.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= next_cfg[i];
      @(posedge clk);
      case (3'(i))
        gvc_pkg::REG_PLANET_COUNT:    cnt_reg = next_cfg[i][4:0];
        gvc_pkg::REG_OBJECT_RADIUS:   obj_r = next_cfg[i][15:0];
        gvc_pkg::REG_SCREEN_WIDTH:    scr_w = next_cfg[i][11:0];
        gvc_pkg::REG_SCREEN_HEIGHT:   scr_h = next_cfg[i][11:0];
        gvc_pkg::REG_TIME_STEP:       step_h = next_cfg[i][15:0];
        gvc_pkg::REG_WORMHOLE_X:      hole_x = $signed(next_cfg[i]);
        gvc_pkg::REG_WORMHOLE_Y:      hole_y = $signed(next_cfg[i]);
        gvc_pkg::REG_WORMHOLE_RADIUS: hole_r = next_cfg[i][15:0];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    gvc_pkg::out_item_t got, want;
    forever begin
      w = quiet ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        hold_req = 1'b0;
        w = 3000;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      results_seen++;
      if (got.hit_planet || got.out_of_bounds || got.in_wormhole) hits_seen++;
      if (body_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %p", got);
      end else begin
        want = body_states.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pos %h,%h/%h,%h vel %h,%h/%h,%h flags %b/%b",
                     got.pos_x, got.pos_y, want.pos_x, want.pos_y,
                     got.vel_x, got.vel_y, want.vel_x, want.vel_y,
                     {got.hit_planet, got.out_of_bounds, got.in_wormhole, got.frozen},
                     {want.hit_planet, want.out_of_bounds, want.in_wormhole, want.frozen});
        end
      end
    end
  end

  // stimulus
  typedef struct {
    bit                 cfg_first;
    gvc_pkg::in_item_t  item;
    bit                 typed;
    gvc_pkg::out_item_t want;
  } row_t;

  initial begin
    row_t rows [$];
    gvc_pkg::out_item_t none;
    gvc_pkg::out_item_t at_rest;
    int n_items;
    none = '0;
    at_rest = mk_out(32'h0190_0000, 32'h012C_0000, 4'b0000);
    next_cfg = '{32'd0, 32'd2560, 32'd800, 32'd600, 32'd1092, 32'd0, 32'd0, 32'd0};

    // tick after reset at the origin leaves the screen, frozen ticks and unused op
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 4'b0101)});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 4'b0001)});
    rows.push_back('{0, mk_in(2'd3, 4'hf, '1, '1, '1, '1), 1, mk_out(0, 0, 4'b0001)});
    rows.push_back('{0, mk_in(gvc_pkg::OP_PLACE, 0, 32'h0190_0000, 32'h012C_0000, 0, 0),
                     1, at_rest});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 1, at_rest});
    // table loads at the field extremes
    rows.push_back('{0, mk_in(gvc_pkg::OP_LOAD, 0, 32'h0190_0000, 32'h00C8_0000, '1, 16'h1000),
                     1, at_rest});
    rows.push_back('{0, mk_in(gvc_pkg::OP_LOAD, 1, 32'h8000_0000, 32'h7fff_ffff, 0, '1),
                     1, at_rest});
    rows.push_back('{0, mk_in(gvc_pkg::OP_LOAD, 15, 32'h7fff_ffff, 32'h8000_0000,
                              32'h0001_0000, 0), 1, at_rest});
    // two planets: saturating pull, distant planet halving, zero distance
    rows.push_back('{1, mk_in(gvc_pkg::OP_PLACE, 0, 32'h0190_0000, 32'h00FA_0000, 0, 0),
                     0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_PLACE, 0, 32'h0190_0000, 32'h00C8_0000, 0, 0),
                     0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_PLACE, 0, 32'h8000_0000, 32'h8000_0000, 0, 0),
                     0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_PLACE, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0),
                     0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(2'd3, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{0, mk_in(gvc_pkg::OP_LOAD, 1, 32'h0064_0000, 32'h0064_0000,
                              32'h0100_0000, 16'h0800), 0, none});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].cfg_first) begin
        next_cfg[gvc_pkg::REG_PLANET_COUNT] = 32'd2;
        apply_cfg();
      end
      send(rows[i].item, rows[i].typed, rows[i].want);
    end

    // fill the whole table so every count is legal
    for (int i = 0; i < 16; i++)
      send(mk_in(gvc_pkg::OP_LOAD, 4'(i), $urandom_range(0, 800) * 65536,
                 $urandom_range(0, 600) * 65536,
                 $urandom_range(0, 32'h0800_0000), $urandom_range(0, 4096)), 0, none);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      next_cfg[gvc_pkg::REG_PLANET_COUNT] = (ph == 5) ? 16 : (ph == 9) ? 31 :
                                            $urandom_range(0, 3);
      next_cfg[gvc_pkg::REG_OBJECT_RADIUS] = (ph == 2) ? 0 : (ph == 7) ? 65535 :
                                             $urandom_range(256, 5120);
      next_cfg[gvc_pkg::REG_SCREEN_WIDTH] = (ph == 3) ? 1 : (ph == 6) ? 4095 :
                                            $urandom_range(200, 1200);
      next_cfg[gvc_pkg::REG_SCREEN_HEIGHT] = (ph == 3) ? 1 : (ph == 6) ? 4095 :
                                             $urandom_range(200, 1200);
      next_cfg[gvc_pkg::REG_TIME_STEP] = (ph == 4) ? 1 : (ph == 8) ? 65535 :
                                         $urandom_range(500, 8000);
      next_cfg[gvc_pkg::REG_WORMHOLE_X] = (ph == 10) ? 32'h8000_0000 :
          (ph == 11) ? 32'h7fff_ffff :
          $urandom_range(0, next_cfg[gvc_pkg::REG_SCREEN_WIDTH]) * 65536;
      next_cfg[gvc_pkg::REG_WORMHOLE_Y] = (ph == 10) ? 32'h8000_0000 :
          (ph == 11) ? 32'h7fff_ffff :
          $urandom_range(0, next_cfg[gvc_pkg::REG_SCREEN_HEIGHT]) * 65536;
      next_cfg[gvc_pkg::REG_WORMHOLE_RADIUS] = (ph == 10) ? 65535 : $urandom_range(0, 8192);
      apply_cfg();
      quiet = (ph % 4 == 1);
      if (ph == 2) hold_req = 1'b1;
      n_items = (ph == 5 || ph == 9) ? 15 : 50;
      send(mk_in(gvc_pkg::OP_PLACE, 0, $urandom_range(0, int'(scr_w)) * 65536,
                 $urandom_range(0, int'(scr_h)) * 65536, 0, 0), 0, none);
      for (int i = 1; i < n_items; i++) send(random_item(), 0, none);
    end

    in_valid <= 1'b0;
    while (body_states.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d items sent (%0d ticks), %0d results checked, %0d collisions seen",
             items_sent, ticks_sent, results_seen, hits_seen);
    $display("twelve register settings with extremes, mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("timeout with %0d results outstanding", body_states.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
